// File: hdl/dsds_pkg.sv
`default_nettype none
package dsds_pkg;

    localparam int unsigned ACTION_W    = 2;
    localparam int unsigned DIST_W      = 16;
    localparam int unsigned STEPS_W     = 16;
    localparam int unsigned PHASE_W     = 3;
    localparam int unsigned COIL_W      = 8;
    localparam int unsigned POS_W       = 32;
    localparam int unsigned HEADING_W   = 2;

    localparam logic [STEPS_W-1:0] TURN_STEPS_RESET = STEPS_W'(2200 / 2);

    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FWD   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LEFT  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_RIGHT = 2'd3;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_FWD   = 2'd1,
        MODE_LEFT  = 2'd2,
        MODE_RIGHT = 2'd3
    } mode_t;

    typedef enum logic [HEADING_W-1:0] {
        HEAD_PLUS_Y  = 2'd0,
        HEAD_PLUS_X  = 2'd1,
        HEAD_MINUS_Y = 2'd2,
        HEAD_MINUS_X = 2'd3
    } heading_t;

    typedef struct packed {
        logic [COIL_W-1:0]    coil_pattern;
        logic                 ready_pulse;
        logic                 busy_res;
        logic                 running;
        logic [POS_W-1:0]     pos_x;
        logic [POS_W-1:0]     pos_y;
        logic [HEADING_W-1:0] heading;
    } result_t;

    function automatic logic [3:0] half_step(input logic [PHASE_W-1:0] phase);
        logic [3:0] pat;
        unique case (phase)
            3'd0: pat = 4'b0001;
            3'd1: pat = 4'b0011;
            3'd2: pat = 4'b0010;
            3'd3: pat = 4'b0110;
            3'd4: pat = 4'b0100;
            3'd5: pat = 4'b1100;
            3'd6: pat = 4'b1000;
            default: pat = 4'b1001;
        endcase
        return pat;
    endfunction

endpackage
`default_nettype wire

// File: hdl/dsds_core.sv
`default_nettype none
module dsds_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          step_en,
    input  wire logic [dsds_pkg::ACTION_W-1:0] action,
    input  wire logic [dsds_pkg::DIST_W-1:0]   distance,
    input  wire logic                          switch_pressed,
    input  wire logic [dsds_pkg::STEPS_W-1:0]  turn_step_count,
    output dsds_pkg::result_t                  result
);
    import dsds_pkg::*;

    logic                 run_reg, run_next;
    mode_t                mode_reg, mode_next;
    logic [STEPS_W-1:0]   steps_reg, steps_next;
    logic [PHASE_W-1:0]   lphase_reg, lphase_next;
    logic [PHASE_W-1:0]   rphase_reg, rphase_next;
    logic [COIL_W-1:0]    coil_reg, coil_next;
    logic [POS_W-1:0]     x_reg, x_next;
    logic [POS_W-1:0]     y_reg, y_next;
    heading_t             heading_reg, heading_next;
    logic                 finish;
    logic                 ready_pulse;

    always_comb begin
        run_next     = run_reg;
        mode_next    = mode_reg;
        steps_next   = steps_reg;
        lphase_next  = lphase_reg;
        rphase_next  = rphase_reg;
        coil_next    = coil_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        heading_next = heading_reg;
        finish       = 1'b0;
        ready_pulse  = 1'b0;

        if (!run_reg) begin
            if (switch_pressed) begin
                run_next    = 1'b1;
                ready_pulse = 1'b1;
            end
        end else if (mode_reg == MODE_IDLE) begin
            if (action != ACT_TICK) begin
                mode_next  = mode_t'(action);
                steps_next = (action == ACT_FWD) ? distance : turn_step_count;
                if (steps_next == '0) begin
                    finish = 1'b1;
                end
            end
        end else if (action == ACT_TICK) begin
            if (steps_reg != '0) begin
                coil_next  = {half_step(rphase_reg), half_step(lphase_reg)};
                steps_next = steps_reg - 1'b1;
                unique case (mode_reg)
                    MODE_FWD: begin
                        lphase_next = lphase_reg - 1'b1;
                        rphase_next = rphase_reg + 1'b1;
                        unique case (heading_reg)
                            HEAD_PLUS_Y:  y_next = y_reg + 1'b1;
                            HEAD_PLUS_X:  x_next = x_reg + 1'b1;
                            HEAD_MINUS_Y: y_next = y_reg - 1'b1;
                            default:      x_next = x_reg - 1'b1;
                        endcase
                    end
                    MODE_LEFT: begin
                        lphase_next = lphase_reg - 1'b1;
                        rphase_next = rphase_reg - 1'b1;
                    end
                    default: begin
                        lphase_next = lphase_reg + 1'b1;
                        rphase_next = rphase_reg + 1'b1;
                    end
                endcase
            end
            if (switch_pressed) begin
                run_next = 1'b0;
            end
            if (steps_next == '0 || !run_next) begin
                finish = 1'b1;
            end
        end

        if (finish) begin
            ready_pulse = 1'b1;
            if (mode_next == MODE_LEFT) begin
                heading_next = heading_t'(heading_reg - 1'b1);
            end else if (mode_next == MODE_RIGHT) begin
                heading_next = heading_t'(heading_reg + 1'b1);
            end
            mode_next  = MODE_IDLE;
            steps_next = '0;
        end
    end

    always_comb begin
        result.coil_pattern = coil_next;
        result.ready_pulse  = ready_pulse;
        result.busy_res     = (mode_next != MODE_IDLE);
        result.running      = run_next;
        result.pos_x        = x_next;
        result.pos_y        = y_next;
        result.heading      = heading_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= 1'b0;
            mode_reg    <= MODE_IDLE;
            steps_reg   <= '0;
            lphase_reg  <= '0;
            rphase_reg  <= '0;
            coil_reg    <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            heading_reg <= HEAD_PLUS_Y;
        end else if (step_en) begin
            run_reg     <= run_next;
            mode_reg    <= mode_next;
            steps_reg   <= steps_next;
            lphase_reg  <= lphase_next;
            rphase_reg  <= rphase_next;
            coil_reg    <= coil_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            heading_reg <= heading_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/differential_stepper_drive_sequencer.sv
`default_nettype none
// Half-step sequencer for a two-motor differential drive. A switch press
// arms the drive; while armed and idle it takes forward (s_distance half
// steps), turn-left and turn-right commands, and each later tick transfer
// makes one half step, updating coils and, going forward, x/y position;
// heading changes as a turn ends. Every input transfer yields exactly one
// result transfer. The block takes one item per cycle while m_ready is
// high: an input register feeds the step logic, which updates the drive
// state and loads the result register, and the input side keeps accepting
// while a result waits as long as the result register is freed in the
// same cycle. The turn length register (reset 1100) is written over the
// cfg port, which is always ready; write it only while the drive is idle.
module differential_stepper_drive_sequencer (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    input  wire logic                             s_valid,
    output      logic                             s_ready,
    input  wire logic [dsds_pkg::ACTION_W-1:0]    s_action,
    input  wire logic [dsds_pkg::DIST_W-1:0]      s_distance,
    input  wire logic                             s_switch_pressed,

    output      logic                             m_valid,
    input  wire logic                             m_ready,
    output      logic [dsds_pkg::COIL_W-1:0]      m_coil_pattern,
    output      logic                             m_ready_pulse,
    output      logic                             m_busy_res,
    output      logic                             m_running,
    output      logic signed [dsds_pkg::POS_W-1:0] m_pos_x,
    output      logic signed [dsds_pkg::POS_W-1:0] m_pos_y,
    output      logic [dsds_pkg::HEADING_W-1:0]   m_heading,

    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [dsds_pkg::STEPS_W-1:0]     cfg_data
);
    import dsds_pkg::*;

    logic                 in_valid_reg;
    logic [ACTION_W-1:0]  action_reg;
    logic [DIST_W-1:0]    distance_reg;
    logic                 switch_reg;
    logic                 out_valid_reg;
    result_t              result_reg;
    result_t              result_next;
    logic [STEPS_W-1:0]   turn_steps_reg;
    logic                 advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            turn_steps_reg <= TURN_STEPS_RESET;
        end else if (cfg_valid) begin
            turn_steps_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg   <= s_action;
            distance_reg <= s_distance;
            switch_reg   <= s_switch_pressed;
        end
    end

    dsds_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step_en         (advance),
        .action          (action_reg),
        .distance        (distance_reg),
        .switch_pressed  (switch_reg),
        .turn_step_count (turn_steps_reg),
        .result          (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_coil_pattern = result_reg.coil_pattern;
    assign m_ready_pulse  = result_reg.ready_pulse;
    assign m_busy_res     = result_reg.busy_res;
    assign m_running      = result_reg.running;
    assign m_pos_x        = signed'(result_reg.pos_x);
    assign m_pos_y        = signed'(result_reg.pos_y);
    assign m_heading      = result_reg.heading;

endmodule
`default_nettype wire
